/* sv/scbc_pkg.sv */
// Shared types, constants and width helpers for the skin chroma block classifier.
package scbc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_STAGES    = 8;

  localparam int PIX_W  = 8;
  localparam int NPIX   = 4;
  localparam int NCH    = 3;
  localparam int IN_W   = NPIX * NCH * PIX_W;
  localparam int OUT_W  = 8;
  localparam int USER_W = 2;

  localparam int SW    = 10;          // width of r+g+b of the averaged block
  localparam int S2W   = 2 * SW;
  localparam int MEAN_W = 16;
  localparam int COEF_W = 32;
  localparam int MS_W  = MEAN_W + SW;  // mean times s
  localparam int TPW   = COEF_W + S2W; // det_threshold times s*s
  localparam int LO_W  = 32;          // low slice of the inner term

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [SW-1:0]     DARK_LIMIT = SW'(50);
  localparam logic [OUT_W-1:0]  MASK_KEEP  = 8'hFF;

  localparam logic [MEAN_W-1:0] MEAN_R_RST    = 16'd16384;
  localparam logic [MEAN_W-1:0] MEAN_G_RST    = 16'd16384;
  localparam logic [COEF_W-1:0] CROSS_RST     = 32'hFFFF_C71C;
  localparam logic [COEF_W-1:0] G_COEF_RST    = 32'd65536;
  localparam logic [COEF_W-1:0] DET_THR_RST   = 32'd7282;
  localparam logic [OUT_W-1:0]  MASK_VAL_RST  = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEAN_R     = 3'd0,
    CFG_MEAN_G     = 3'd1,
    CFG_CROSS_COEF = 3'd2,
    CFG_G_COEF     = 3'd3,
    CFG_DET_THR    = 3'd4,
    CFG_MASK_VALUE = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_r;
    logic [MEAN_W-1:0] mean_g;
    logic [COEF_W-1:0] cross_coef;
    logic [COEF_W-1:0] g_coef;
    logic [COEF_W-1:0] det_threshold;
    logic [OUT_W-1:0]  mask_value;
  } cfg_t;

  // Signed width of DX/DY: r*M against mean*s, whichever is wider, plus sign.
  function automatic int dev_width(input int f);
    int w;
    w = (f + PIX_W > MS_W) ? f + PIX_W : MS_W;
    return w + 1;
  endfunction

  // Width of both sides of the final compare.
  function automatic int cmp_width(input int f);
    return 2 * dev_width(f) + 36;
  endfunction

endpackage

/* sv/scbc_flow.sv */
// Valid and load control for the classifier pipeline.
module scbc_flow #(
  parameter int NST = scbc_pkg::NUM_STAGES
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           out_ready,
  output logic           in_ready,
  output logic [NST-1:0] load,
  output logic [NST-1:0] vld
);
  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic [NST:0]   rdy;

  // A stage takes new data when it is empty or its content moves on.
  always_comb begin
    rdy[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NST; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign load     = rdy[NST-1:0];
  assign vld      = vld_r;
  assign in_ready = rdy[0];
endmodule

/* sv/scbc_avg.sv */
// Block averaging, brightness test and chroma deviation (stages 1 and 2).
module scbc_avg #(
  parameter int FRAC_BITS = scbc_pkg::FRAC_BITS_DEF
) (
  input  logic                                          clk,
  input  logic [1:0]                                    load,
  input  logic [scbc_pkg::IN_W-1:0]                     pix,
  input  scbc_pkg::cfg_t                                cfg,
  output logic signed [scbc_pkg::dev_width(FRAC_BITS)-1:0] dx,
  output logic signed [scbc_pkg::dev_width(FRAC_BITS)-1:0] dy,
  output logic [scbc_pkg::S2W-1:0]                      s2,
  output logic                                          bright
);
  import scbc_pkg::*;

  localparam int DW = dev_width(FRAC_BITS);

  logic [SW-1:0]    ch_sum [NCH];
  logic [PIX_W-1:0] ch_avg [NCH];
  logic [SW-1:0]    s_nxt;

  logic [PIX_W-1:0] r1_r, g1_r;
  logic [SW-1:0]    s1_r;
  logic             b1_r;

  logic [MS_W-1:0]      mr_s, mg_s;
  logic signed [DW-1:0] dx_nxt, dy_nxt, dx_r, dy_r;
  logic [S2W-1:0]       s2_nxt, s2_r;
  logic                 b2_r;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      ch_sum[c] = '0;
      for (int p = 0; p < NPIX; p++) begin
        ch_sum[c] = ch_sum[c] + SW'(pix[(p*NCH+c)*PIX_W +: PIX_W]);
      end
      ch_avg[c] = ch_sum[c][SW-1:2];
    end
    s_nxt = SW'(ch_avg[0]) + SW'(ch_avg[1]) + SW'(ch_avg[2]);
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      r1_r <= ch_avg[0];
      g1_r <= ch_avg[1];
      s1_r <= s_nxt;
      b1_r <= (s_nxt >= DARK_LIMIT);
    end
  end

  assign mr_s   = MS_W'(cfg.mean_r) * MS_W'(s1_r);
  assign mg_s   = MS_W'(cfg.mean_g) * MS_W'(s1_r);
  assign dx_nxt = $signed((DW'(r1_r) << FRAC_BITS) - DW'(mr_s));
  assign dy_nxt = $signed((DW'(g1_r) << FRAC_BITS) - DW'(mg_s));
  assign s2_nxt = S2W'(s1_r) * S2W'(s1_r);

  always_ff @(posedge clk) begin
    if (load[1]) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      s2_r <= s2_nxt;
      b2_r <= b1_r;
    end
  end

  assign dx     = dx_r;
  assign dy     = dy_r;
  assign s2     = s2_r;
  assign bright = b2_r;
endmodule

/* sv/scbc_quad.sv */
// Quadratic form of the skin model and threshold term (stages 3 to 7).
module scbc_quad #(
  parameter int FRAC_BITS = scbc_pkg::FRAC_BITS_DEF
) (
  input  logic                                            clk,
  input  logic [4:0]                                      load,
  input  logic signed [scbc_pkg::dev_width(FRAC_BITS)-1:0] dx,
  input  logic signed [scbc_pkg::dev_width(FRAC_BITS)-1:0] dy,
  input  logic [scbc_pkg::S2W-1:0]                        s2,
  input  logic                                            bright_in,
  input  scbc_pkg::cfg_t                                  cfg,
  output logic signed [scbc_pkg::cmp_width(FRAC_BITS)-1:0] lhs,
  output logic signed [scbc_pkg::cmp_width(FRAC_BITS)-1:0] rhs,
  output logic                                            bright_out
);
  import scbc_pkg::*;

  localparam int DW  = dev_width(FRAC_BITS);
  localparam int GXW = DW + COEF_W + 1;
  localparam int YCW = DW + COEF_W;
  localparam int YYW = 2 * DW;
  localparam int IW  = DW + COEF_W + 2;
  localparam int HW  = IW - LO_W;
  localparam int PLW = DW + LO_W + 1;
  localparam int PHW = DW + HW;
  localparam int LW  = cmp_width(FRAC_BITS);

  // stage 3
  logic signed [GXW-1:0] gx_nxt, gx_r;
  logic signed [YCW-1:0] yc_nxt, yc_r;
  logic signed [YYW-1:0] yy_nxt, yy_r;
  logic [TPW-1:0]        tp_nxt, tp_r;
  logic signed [DW-1:0]  dx3_r;
  logic                  b3_r;
  // stage 4
  logic signed [IW-1:0]  inner_nxt, inner_r;
  logic signed [LW-1:0]  yym_nxt, yym4_r;
  logic signed [LW-1:0]  rhs_nxt, rhs4_r;
  logic signed [DW-1:0]  dx4_r;
  logic                  b4_r;
  // stage 5
  logic signed [PLW-1:0] pl_nxt, pl_r;
  logic signed [PHW-1:0] ph_nxt, ph_r;
  logic signed [LW-1:0]  yym5_r, rhs5_r;
  logic                  b5_r;
  // stage 6
  logic signed [LW-1:0]  t_nxt, t_r;
  logic signed [PHW-1:0] ph6_r;
  logic signed [LW-1:0]  rhs6_r;
  logic                  b6_r;
  // stage 7
  logic signed [LW-1:0]  lhs_nxt, lhs_r, rhs7_r;
  logic                  b7_r;

  assign gx_nxt = dx * $signed({1'b0, cfg.g_coef});
  assign yc_nxt = dy * $signed(cfg.cross_coef);
  assign yy_nxt = dy * dy;
  assign tp_nxt = TPW'(cfg.det_threshold) * TPW'(s2);

  always_ff @(posedge clk) begin
    if (load[0]) begin
      gx_r  <= gx_nxt;
      yc_r  <= yc_nxt;
      yy_r  <= yy_nxt;
      tp_r  <= tp_nxt;
      dx3_r <= dx;
      b3_r  <= bright_in;
    end
  end

  assign inner_nxt = IW'(gx_r) - IW'(yc_r);
  assign yym_nxt   = LW'(yy_r) << FRAC_BITS;
  assign rhs_nxt   = $signed(LW'(tp_r) << (2 * FRAC_BITS));

  always_ff @(posedge clk) begin
    if (load[1]) begin
      inner_r <= inner_nxt;
      yym4_r  <= yym_nxt;
      rhs4_r  <= rhs_nxt;
      dx4_r   <= dx3_r;
      b4_r    <= b3_r;
    end
  end

  // Split DX*inner into a low and a high partial product.
  assign pl_nxt = dx4_r * $signed({1'b0, inner_r[LO_W-1:0]});
  assign ph_nxt = dx4_r * $signed(inner_r[IW-1:LO_W]);

  always_ff @(posedge clk) begin
    if (load[2]) begin
      pl_r   <= pl_nxt;
      ph_r   <= ph_nxt;
      yym5_r <= yym4_r;
      rhs5_r <= rhs4_r;
      b5_r   <= b4_r;
    end
  end

  assign t_nxt = LW'(pl_r) + yym5_r;

  always_ff @(posedge clk) begin
    if (load[3]) begin
      t_r    <= t_nxt;
      ph6_r  <= ph_r;
      rhs6_r <= rhs5_r;
      b6_r   <= b5_r;
    end
  end

  assign lhs_nxt = (LW'(ph6_r) << LO_W) + t_r;

  always_ff @(posedge clk) begin
    if (load[4]) begin
      lhs_r  <= lhs_nxt;
      rhs7_r <= rhs6_r;
      b7_r   <= b6_r;
    end
  end

  assign lhs        = lhs_r;
  assign rhs        = rhs7_r;
  assign bright_out = b7_r;
endmodule

/* sv/skin_chroma_block_classifier_unit.sv */
// Top level of the skin chroma block classifier: config registers, pipeline, result stage.
// Classifies one 2x2 RGB block per cycle: the block is averaged, rejected as dark when the
// averaged r+g+b is below 50, and otherwise tested against a Gaussian skin model in
// normalized rg chromaticity, evaluated exactly in fixed point without a divider. The
// pipeline has eight register stages and takes a new block every cycle while the output
// is not stalled; the depth is set by the chain of multiplications, where the product of
// DX with the inner term is formed as two partial products. A stalled output holds the
// pipeline, and empty stages keep filling meanwhile.
// Configuration writes are taken every cycle and must only happen while the block is idle.
module skin_chroma_block_classifier_unit #(
  parameter int FRAC_BITS = scbc_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // red, green, blue of top-left, then top-right, bottom-left, bottom-right (8 bits each)
  input  logic [scbc_pkg::IN_W-1:0]       in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // mask_and
  output logic [scbc_pkg::OUT_W-1:0]      out_tdata,
  // is_skin, bright_enough
  output logic [scbc_pkg::USER_W-1:0]     out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [scbc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scbc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import scbc_pkg::*;

  localparam int DW = dev_width(FRAC_BITS);
  localparam int LW = cmp_width(FRAC_BITS);

  cfg_t cfg_r, cfg_nxt;

  logic [NUM_STAGES-1:0] load, vld;

  logic signed [DW-1:0] dx, dy;
  logic [S2W-1:0]       s2;
  logic                 bright2, bright7;
  logic signed [LW-1:0] lhs, rhs;

  logic             skin_nxt;
  logic             skin_r, bright_r;
  logic [OUT_W-1:0] mask_r;

  // Config registers
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MEAN_R:     cfg_nxt.mean_r        = cfg_data[MEAN_W-1:0];
        CFG_MEAN_G:     cfg_nxt.mean_g        = cfg_data[MEAN_W-1:0];
        CFG_CROSS_COEF: cfg_nxt.cross_coef    = cfg_data[COEF_W-1:0];
        CFG_G_COEF:     cfg_nxt.g_coef        = cfg_data[COEF_W-1:0];
        CFG_DET_THR:    cfg_nxt.det_threshold = cfg_data[COEF_W-1:0];
        CFG_MASK_VALUE: cfg_nxt.mask_value    = cfg_data[OUT_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mean_r        <= MEAN_R_RST;
      cfg_r.mean_g        <= MEAN_G_RST;
      cfg_r.cross_coef    <= CROSS_RST;
      cfg_r.g_coef        <= G_COEF_RST;
      cfg_r.det_threshold <= DET_THR_RST;
      cfg_r.mask_value    <= MASK_VAL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  scbc_flow #(.NST(NUM_STAGES)) u_flow (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_ready(out_tready),
    .in_ready (in_tready),
    .load     (load),
    .vld      (vld)
  );

  scbc_avg #(.FRAC_BITS(FRAC_BITS)) u_avg (
    .clk   (clk),
    .load  (load[1:0]),
    .pix   (in_tdata),
    .cfg   (cfg_r),
    .dx    (dx),
    .dy    (dy),
    .s2    (s2),
    .bright(bright2)
  );

  scbc_quad #(.FRAC_BITS(FRAC_BITS)) u_quad (
    .clk       (clk),
    .load      (load[6:2]),
    .dx        (dx),
    .dy        (dy),
    .s2        (s2),
    .bright_in (bright2),
    .cfg       (cfg_r),
    .lhs       (lhs),
    .rhs       (rhs),
    .bright_out(bright7)
  );

  // Result stage: final compare, gated by brightness
  assign skin_nxt = bright7 && (lhs < rhs);

  always_ff @(posedge clk) begin
    if (load[NUM_STAGES-1]) begin
      skin_r   <= skin_nxt;
      bright_r <= bright7;
      mask_r   <= skin_nxt ? cfg_r.mask_value : MASK_KEEP;
    end
  end

  assign out_tvalid = vld[NUM_STAGES-1];
  assign out_tdata  = mask_r;
  assign out_tuser  = {bright_r, skin_r};

  a_skin_needs_bright: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tuser[0] || out_tuser[1]))
    else $error("skin result on a dark block");

  a_mask_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == MASK_KEEP))
    else $error("mask changed on a non-skin block");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld[0])
    else $error("accepted transfer did not enter the pipeline");
endmodule

/* tb/testbench.sv */
// Self-checking testbench for the skin chroma block classifier: stream driver, monitor, model.
`timescale 1ns / 1ps

module testbench;
  import scbc_pkg::*;

  localparam int FRAC_BITS      = FRAC_BITS_DEF;
  localparam int SETTLE_CYCLES  = NUM_STAGES + 4;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 8;
  localparam int BLOCKS_PER_PHASE = 235;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic             is_skin;
    logic             bright;
    logic [OUT_W-1:0] mask_and;
  } skin_verdict_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic [USER_W-1:0]     out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  skin_chroma_block_classifier_unit #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cfg_t model_regs = '{mean_r: MEAN_R_RST, mean_g: MEAN_G_RST, cross_coef: CROSS_RST,
                       g_coef: G_COEF_RST, det_threshold: DET_THR_RST,
                       mask_value: MASK_VAL_RST};

  logic [IN_W-1:0] pending_blocks [$];
  skin_verdict_t   expected_verdicts [$];

  int error_count = 0;
  int blocks_queued = 0;
  int results_checked = 0;
  int skin_seen = 0;
  int dark_seen = 0;
  int cfg_writes = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit pressure_request = 1'b0;
  bit pressure_done = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Average the 2x2 block, reject dark blocks, then run the exact chromaticity test.
  function automatic skin_verdict_t classify_block(input logic [IN_W-1:0] blk,
                                                   input cfg_t regs);
    logic [9:0] chan_sum [NCH];
    logic signed [127:0] avg_r, avg_g, sum_s, one, dx, dy, inner, lhs, rhs;
    skin_verdict_t v;
    int p, c;
    for (c = 0; c < NCH; c++) chan_sum[c] = '0;
    for (p = 0; p < NPIX; p++)
      for (c = 0; c < NCH; c++)
        chan_sum[c] += blk[PIX_W*(p*NCH+c) +: PIX_W];
    avg_r = 128'(chan_sum[0] >> 2);
    avg_g = 128'(chan_sum[1] >> 2);
    sum_s = avg_r + avg_g + 128'(chan_sum[2] >> 2);
    v.bright = (sum_s >= 128'(DARK_LIMIT));
    v.is_skin = 1'b0;
    if (v.bright) begin
      one = 1;
      one = one << FRAC_BITS;
      dx = avg_r * one - $signed({112'd0, regs.mean_r}) * sum_s;
      dy = avg_g * one - $signed({112'd0, regs.mean_g}) * sum_s;
      inner = dx * $signed({96'd0, regs.g_coef})
            - dy * $signed({{96{regs.cross_coef[31]}}, regs.cross_coef});
      lhs = dx * inner + dy * dy * one;
      rhs = $signed({96'd0, regs.det_threshold}) * sum_s * sum_s * one * one;
      v.is_skin = (lhs < rhs);
    end
    v.mask_and = v.is_skin ? regs.mask_value : MASK_KEEP;
    return v;
  endfunction

  function automatic logic [IN_W-1:0] flat_block(input int r, input int g, input int b);
    logic [IN_W-1:0] blk;
    int p;
    for (p = 0; p < NPIX; p++)
      blk[PIX_W*p*NCH +: PIX_W*NCH] = {b[7:0], g[7:0], r[7:0]};
    return blk;
  endfunction

  // Mostly skin-like tones with jitter; also raw noise, near-dark and nearly flat blocks.
  function automatic logic [IN_W-1:0] random_block();
    logic [IN_W-1:0] blk;
    int base [NCH];
    int kind, v, p, c;
    kind = $urandom_range(99);
    base[0] = $urandom_range(60, 240);
    base[1] = base[0] * $urandom_range(45, 90) / 100;
    base[2] = base[0] * $urandom_range(20, 80) / 100;
    for (p = 0; p < NPIX; p++)
      for (c = 0; c < NCH; c++) begin
        if (kind < 50) v = base[c] + int'($urandom_range(40)) - 20;
        else if (kind < 70) v = $urandom_range(255);
        else if (kind < 85) v = $urandom_range(30);
        else v = base[c] + int'($urandom_range(3));
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        blk[PIX_W*(p*NCH+c) +: PIX_W] = v[7:0];
      end
    return blk;
  endfunction

  function automatic logic [31:0] rand_scaled();
    return $urandom >> $urandom_range(31);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MEAN_R:     model_regs.mean_r        = data[MEAN_W-1:0];
      CFG_MEAN_G:     model_regs.mean_g        = data[MEAN_W-1:0];
      CFG_CROSS_COEF: model_regs.cross_coef    = data;
      CFG_G_COEF:     model_regs.g_coef        = data;
      CFG_DET_THR:    model_regs.det_threshold = data;
      CFG_MASK_VALUE: model_regs.mask_value    = data[OUT_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic write_model(input logic [31:0] mr, mg, cc, gc, dt, mv);
    write_reg(CFG_MEAN_R, mr);
    write_reg(CFG_MEAN_G, mg);
    write_reg(CFG_CROSS_COEF, cc);
    write_reg(CFG_G_COEF, gc);
    write_reg(CFG_DET_THR, dt);
    write_reg(CFG_MASK_VALUE, mv);
  endtask

  task automatic queue_block(input logic [IN_W-1:0] blk);
    pending_blocks.push_back(blk);
    blocks_queued++;
  endtask

  task automatic wait_drained();
    while (results_checked != blocks_queued) @(posedge clk);
  endtask

  // Input driver: hold the item until its transfer, then offer the next one or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_verdicts.push_back(classify_block(in_tdata, model_regs));
      if (!in_tvalid || in_tready) begin
        if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata  <= pending_blocks.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output ready: random stalls, plus one long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (pressure_request && !pressure_done) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      pressure_done <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result monitor: compare each transfer against the oldest prediction.
  always @(posedge clk) begin
    skin_verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (out_tuser[0]) skin_seen++;
      if (!out_tuser[1]) dark_seen++;
      if (expected_verdicts.size() == 0) begin
        report_mismatch("result with no block pending, mask_and", out_tdata, -1);
      end else begin
        want = expected_verdicts.pop_front();
        if (out_tuser[0] !== want.is_skin)
          report_mismatch("is_skin", out_tuser[0], want.is_skin);
        if (out_tuser[1] !== want.bright)
          report_mismatch("bright_enough", out_tuser[1], want.bright);
        if (out_tdata !== want.mask_and)
          report_mismatch("mask_and", out_tdata, want.mask_and);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [IN_W-1:0] blk;
    int phase, n;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      if (phase > 0) begin
        repeat (SETTLE_CYCLES) @(posedge clk);
        case (phase)
          1: write_model({16'($urandom_range(65535)), 16'd29491}, 32'd20316,
                         -32'sd8000, 32'd90000, 32'd20000, 32'h5A);
          2: write_model(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
          3: write_model(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                         32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
          4: begin
            // writes to unmapped indexes must leave the model alone
            write_reg(CFG_SPARE_LO, $urandom);
            write_reg(CFG_SPARE_HI, $urandom);
            write_model(32'd0, 32'hFFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'd0);
          end
          default: write_model($urandom, $urandom,
                               rand_scaled() ^ {32{1'($urandom_range(1))}},
                               rand_scaled(), rand_scaled(), $urandom);
        endcase
      end

      @(negedge clk);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      pressure_request = (phase == 4);

      if (phase == 0) begin
        queue_block(flat_block(0, 0, 0));
        queue_block(flat_block(255, 255, 255));
        queue_block(flat_block(16, 17, 17));      // sum exactly at the dark limit
        queue_block(flat_block(16, 16, 17));      // one below the dark limit
        // floor of the average pulls the sum below the limit
        blk = flat_block(17, 17, 17);
        blk[PIX_W*9 +: PIX_W] = 8'd16;
        blk[PIX_W*10 +: PIX_W] = 8'd16;
        queue_block(blk);
        blk = flat_block(16, 17, 17);
        blk[PIX_W*9 +: PIX_W] = 8'd19;
        queue_block(blk);
        queue_block(flat_block(255, 0, 0));
        queue_block(flat_block(0, 255, 0));
        queue_block(flat_block(0, 0, 255));
        queue_block(flat_block(200, 120, 90));
        queue_block(flat_block(150, 100, 80));
        queue_block(flat_block(220, 170, 140));
        queue_block(flat_block(255, 200, 160));
        queue_block({{(IN_W-24){1'b0}}, 24'hFFFFFF});
        queue_block({(IN_W/8){8'hAA}});
        queue_block({(IN_W/8){8'h55}});
        queue_block(flat_block(25, 25, 50));      // right on the model mean
        queue_block(flat_block(0, 0, 50));
        queue_block(flat_block(50, 0, 0));
      end
      for (n = 0; n < BLOCKS_PER_PHASE; n++) queue_block(random_block());
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_verdicts.size() != 0)
      report_mismatch("blocks left without a result", 0, expected_verdicts.size());
    $display("Classified %0d blocks over %0d model settings and four flow patterns,",
             blocks_queued, PHASES);
    $display("with one long output hold-off: %0d skin, %0d dark, %0d register writes.",
             skin_seen, dark_seen, cfg_writes);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
